>>> src/bst_pkg.sv
// Shared types and constants of the byte stream tokenizer.
`timescale 1ns / 1ps

package bst_pkg;

   // Token kinds as they appear on the result channel
   typedef enum logic [1:0] {
      KIND_IDENT  = 2'd0,
      KIND_NUMBER = 2'd1,
      KIND_SYMBOL = 2'd2,
      KIND_END    = 2'd3
   } token_kind_type;

   // Open run tracker, one-hot
   typedef enum logic [2:0] {
      RUN_NONE   = 3'b001,
      RUN_IDENT  = 3'b010,
      RUN_NUMBER = 3'b100
   } run_kind_type;

   localparam logic [7:0] CH_NUL        = 8'd0;
   localparam logic [7:0] CH_TAB        = 8'd9;
   localparam logic [7:0] CH_NEWLINE    = 8'd10;
   localparam logic [7:0] CH_CR         = 8'd13;
   localparam logic [7:0] CH_SPACE      = 8'd32;
   localparam logic [7:0] CH_ZERO       = 8'd48;
   localparam logic [7:0] CH_NINE       = 8'd57;
   localparam logic [7:0] CH_UPPER_A    = 8'd65;
   localparam logic [7:0] CH_UPPER_Z    = 8'd90;
   localparam logic [7:0] CH_UNDERSCORE = 8'd95;
   localparam logic [7:0] CH_LOWER_A    = 8'd97;
   localparam logic [7:0] CH_LOWER_Z    = 8'd122;

   localparam int FIELD_W = 16;

   // Queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = QPTR_W + 1;

   typedef struct packed {
      token_kind_type     kind;
      logic [FIELD_W-1:0] start;
      logic [FIELD_W-1:0] length;
      logic [FIELD_W-1:0] line;
   } token_type;

   // Everything one byte produces: an optional closed run, then an optional
   // symbol or end token
   typedef struct packed {
      logic      run_vld;
      token_type run_tok;
      logic      tail_vld;
      token_type tail_tok;
   } entry_type;

endpackage

>>> src/bst_req_if.sv
// Request channel carrying source text bytes.
`timescale 1ns / 1ps

interface bst_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink (input valid, input text_byte, output ready);
endinterface

>>> src/bst_rsp_if.sv
// Response channel carrying tokens.
`timescale 1ns / 1ps

interface bst_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  token_kind;
   logic [15:0] token_start;
   logic [15:0] token_length;
   logic [15:0] token_line;
   logic        last_of_run;

   modport source (output valid, output token_kind, output token_start,
                   output token_length, output token_line, output last_of_run,
                   input ready);
   modport sink (input valid, input token_kind, input token_start,
                 input token_length, input token_line, input last_of_run,
                 output ready);
endinterface

>>> src/byte_stream_tokenizer_core.sv
// Top level of the byte stream tokenizer: front end, queue and back end.
`timescale 1ns / 1ps

// Byte stream tokenizer.
// req_ch: one source byte per item; a zero byte closes the text.
// rsp_ch: tokens (identifier, number, symbol, end) with start offset, length
//   and starting line; last_of_run marks the final token caused by one byte.
// Whitespace that closes no run and bytes that only open or extend a run produce nothing.
// The front end writes the entry for the byte that closes a token into the queue; the
//   back end then loads the token from there into its output register.
// Throughput: one byte per cycle. A byte that yields two tokens (closed run
//   plus symbol or end token) occupies the back end for both tokens in turn; the
//   four-entry queue absorbs that and req_ch.ready drops only when it fills.
// Stalls: when rsp_ch.ready is low the output item holds, the queue fills,
//   then req_ch.ready falls. No item is dropped.
// Reset: synchronous; no open run, offset 0, line 1, queue and output empty.
// Offset, run length and line saturate at their internal widths
//   (OFFSET_WIDTH, LINE_WIDTH); the 16-bit result fields carry them
//   zero-extended or cut to 16 bits.
module byte_stream_tokenizer_core
   import bst_pkg::*;
#(
   parameter int OFFSET_WIDTH = 16,
   parameter int LINE_WIDTH   = 16
) (
   input logic       clock,
   input logic       reset,
   bst_req_if.sink   req_ch,
   bst_rsp_if.source rsp_ch
);

   logic      q_push, q_pop, q_full, q_empty;
   entry_type push_entry, pop_entry;

   // classify, track runs and counters
   bst_front #(
      .OFFSET_WIDTH (OFFSET_WIDTH),
      .LINE_WIDTH   (LINE_WIDTH)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_entry (push_entry)
   );

   // decouples the two sides
   bst_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .empty      (q_empty)
   );

   // one token per cycle onto the result channel while it is ready and entries wait
   bst_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_entry (pop_entry),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

>>> src/bst_front.sv
// Front end: classifies each byte, tracks runs, offset and line, builds queue entries.
`timescale 1ns / 1ps

module bst_front
   import bst_pkg::*;
#(
   parameter int OFFSET_WIDTH = 16,
   parameter int LINE_WIDTH   = 16
) (
   input  logic      clock,
   input  logic      reset,
   bst_req_if.sink   req_ch,
   input  logic      q_full,
   output logic      q_push,
   output entry_type q_entry
);

   run_kind_type            run_kind_ff, run_kind_in;
   logic [OFFSET_WIDTH-1:0] run_start_ff, run_start_in;
   logic [OFFSET_WIDTH-1:0] run_len_ff, run_len_in;
   logic [LINE_WIDTH-1:0]   run_line_ff, run_line_in;
   logic [OFFSET_WIDTH-1:0] offset_ff, offset_in;
   logic [LINE_WIDTH-1:0]   line_ff, line_in;

   logic       accept;
   logic [7:0] b;
   logic       is_space, is_word, is_digit, run_open;
   token_type  run_tok;

   function automatic logic [FIELD_W-1:0] fit_off(input logic [OFFSET_WIDTH-1:0] v);
      logic [OFFSET_WIDTH+FIELD_W-1:0] w;
      w = (OFFSET_WIDTH + FIELD_W)'(v);
      return w[FIELD_W-1:0];
   endfunction

   function automatic logic [FIELD_W-1:0] fit_line(input logic [LINE_WIDTH-1:0] v);
      logic [LINE_WIDTH+FIELD_W-1:0] w;
      w = (LINE_WIDTH + FIELD_W)'(v);
      return w[FIELD_W-1:0];
   endfunction

   function automatic logic [OFFSET_WIDTH-1:0] sat_off(input logic [OFFSET_WIDTH-1:0] v);
      return (&v) ? v : v + OFFSET_WIDTH'(1);
   endfunction

   function automatic logic [LINE_WIDTH-1:0] sat_line(input logic [LINE_WIDTH-1:0] v);
      return (&v) ? v : v + LINE_WIDTH'(1);
   endfunction

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && !q_full;
   assign b            = req_ch.text_byte;

   assign is_space = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
   assign is_word  = (b >= CH_UPPER_A && b <= CH_UPPER_Z) ||
                     (b >= CH_LOWER_A && b <= CH_LOWER_Z) || (b == CH_UNDERSCORE);
   assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
   assign run_open = (run_kind_ff == RUN_IDENT) || (run_kind_ff == RUN_NUMBER);

   always_comb begin
      run_tok.kind   = (run_kind_ff == RUN_IDENT) ? KIND_IDENT : KIND_NUMBER;
      run_tok.start  = fit_off(run_start_ff);
      run_tok.length = fit_off(run_len_ff);
      run_tok.line   = fit_line(run_line_ff);
   end

   always_comb begin
      run_kind_in  = run_kind_ff;
      run_start_in = run_start_ff;
      run_len_in   = run_len_ff;
      run_line_in  = run_line_ff;
      offset_in    = offset_ff;
      line_in      = line_ff;
      q_entry      = '0;
      q_entry.run_tok = run_tok;

      if (accept) begin
         offset_in = sat_off(offset_ff);
         priority if (b == CH_NUL) begin
            // end of text: close run, end token, restart counters
            q_entry.run_vld  = run_open;
            q_entry.tail_vld = 1'b1;
            q_entry.tail_tok = '{kind: KIND_END, start: fit_off(offset_ff),
                                 length: '0, line: fit_line(line_ff)};
            run_kind_in  = RUN_NONE;
            run_len_in   = '0;
            run_start_in = '0;
            run_line_in  = LINE_WIDTH'(1);
            offset_in    = '0;
            line_in      = LINE_WIDTH'(1);
         end else if (is_space) begin
            q_entry.run_vld = run_open;
            run_kind_in     = RUN_NONE;
            run_len_in      = '0;
            if (b == CH_NEWLINE) begin
               line_in = sat_line(line_ff);
            end
         end else if (is_word) begin
            if (run_kind_ff == RUN_IDENT) begin
               run_len_in = sat_off(run_len_ff);
            end else begin
               // a number run is ended by a letter, which opens an identifier
               q_entry.run_vld = run_open;
               run_kind_in     = RUN_IDENT;
               run_start_in    = offset_ff;
               run_len_in      = OFFSET_WIDTH'(1);
               run_line_in     = line_ff;
            end
         end else if (is_digit) begin
            if (run_open) begin
               run_len_in = sat_off(run_len_ff);
            end else begin
               run_kind_in  = RUN_NUMBER;
               run_start_in = offset_ff;
               run_len_in   = OFFSET_WIDTH'(1);
               run_line_in  = line_ff;
            end
         end else begin
            q_entry.run_vld  = run_open;
            q_entry.tail_vld = 1'b1;
            q_entry.tail_tok = '{kind: KIND_SYMBOL, start: fit_off(offset_ff),
                                 length: FIELD_W'(1), line: fit_line(line_ff)};
            run_kind_in = RUN_NONE;
            run_len_in  = '0;
         end
      end

      q_push = q_entry.run_vld || q_entry.tail_vld;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_kind_ff  <= RUN_NONE;
         run_start_ff <= '0;
         run_len_ff   <= '0;
         run_line_ff  <= LINE_WIDTH'(1);
         offset_ff    <= '0;
         line_ff      <= LINE_WIDTH'(1);
      end else begin
         run_kind_ff  <= run_kind_in;
         run_start_ff <= run_start_in;
         run_len_ff   <= run_len_in;
         run_line_ff  <= run_line_in;
         offset_ff    <= offset_in;
         line_ff      <= line_in;
      end
   end

endmodule

>>> src/bst_queue.sv
// Short queue of per-byte token entries between front and back.
`timescale 1ns / 1ps

module bst_queue
   import bst_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output entry_type pop_entry,
   output logic      empty
);

   entry_type         mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   assign full      = (count_ff == QCNT_W'(QDEPTH));
   assign empty     = (count_ff == '0);
   assign pop_entry = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + QCNT_W'(1);
            2'b01:   count_ff <= count_ff - QCNT_W'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("queue read while empty");
`endif

endmodule

>>> src/bst_back.sv
// Back end: unpacks queue entries into single tokens behind an output register.
`timescale 1ns / 1ps

module bst_back
   import bst_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      q_empty,
   input  entry_type q_entry,
   output logic      q_pop,
   bst_rsp_if.source rsp_ch
);

   logic      rsp_vld_ff, rsp_vld_in;
   token_type rsp_tok_ff, rsp_tok_in;
   logic      rsp_last_ff, rsp_last_in;
   logic      pend_ff, pend_in;
   token_type pend_tok_ff, pend_tok_in;
   logic      load;

   assign load = !rsp_vld_ff || rsp_ch.ready;

   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_tok_in  = rsp_tok_ff;
      rsp_last_in = rsp_last_ff;
      pend_in     = pend_ff;
      pend_tok_in = pend_tok_ff;
      q_pop       = 1'b0;
      if (load) begin
         priority if (pend_ff) begin
            rsp_vld_in  = 1'b1;
            rsp_tok_in  = pend_tok_ff;
            rsp_last_in = 1'b1;
            pend_in     = 1'b0;
         end else if (!q_empty) begin
            q_pop      = 1'b1;
            rsp_vld_in = 1'b1;
            if (q_entry.run_vld) begin
               rsp_tok_in  = q_entry.run_tok;
               rsp_last_in = !q_entry.tail_vld;
               pend_in     = q_entry.tail_vld;
               pend_tok_in = q_entry.tail_tok;
            end else begin
               rsp_tok_in  = q_entry.tail_tok;
               rsp_last_in = 1'b1;
            end
         end else begin
            rsp_vld_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
         pend_ff    <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
         pend_ff    <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tok_ff  <= rsp_tok_in;
      rsp_last_ff <= rsp_last_in;
      pend_tok_ff <= pend_tok_in;
   end

   assign rsp_ch.valid        = rsp_vld_ff;
   assign rsp_ch.token_kind   = rsp_tok_ff.kind;
   assign rsp_ch.token_start  = rsp_tok_ff.start;
   assign rsp_ch.token_length = rsp_tok_ff.length;
   assign rsp_ch.token_line   = rsp_tok_ff.line;
   assign rsp_ch.last_of_run  = rsp_last_ff;

`ifndef SYNTHESIS
   a_pend_behind_run: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (rsp_vld_ff && !rsp_last_ff))
      else $error("held tail token without a run token in front of it");

   a_run_has_tail: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_last_ff) |-> pend_ff)
      else $error("non-final token shown with no tail token held");
`endif

endmodule

>>> tb/tb_checker.sv
// Token predictor and scoreboard for the byte stream tokenizer.
`timescale 1ns / 1ps

module tb_checker
   import bst_pkg::*;
#(
   parameter int OFFSET_WIDTH = 16,
   parameter int LINE_WIDTH   = 16
) (
   input  logic clock,
   input  logic reset,
   bst_req_if   req_ch,
   bst_rsp_if   rsp_ch,
   output int   fail_count,
   output int   outstanding
);

   typedef struct packed {
      token_type tok;
      logic      last;
   } expected_token_type;

   expected_token_type pending_tokens[$];
   int                 mismatches = 0;

   // Predictor state
   run_kind_type            run_state;
   logic [OFFSET_WIDTH-1:0] run_start;
   logic [OFFSET_WIDTH-1:0] run_length;
   logic [LINE_WIDTH-1:0]   run_line;
   logic [OFFSET_WIDTH-1:0] byte_offset;
   logic [LINE_WIDTH-1:0]   line_count;

   assign fail_count = mismatches;

   function automatic logic [OFFSET_WIDTH-1:0] offset_inc(logic [OFFSET_WIDTH-1:0] v);
      return (&v) ? v : v + OFFSET_WIDTH'(1);
   endfunction

   function automatic logic [LINE_WIDTH-1:0] line_inc(logic [LINE_WIDTH-1:0] v);
      return (&v) ? v : v + LINE_WIDTH'(1);
   endfunction

   function automatic bit is_blank(logic [7:0] b);
      return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
   endfunction

   function automatic bit is_word_start(logic [7:0] b);
      return (b >= CH_UPPER_A && b <= CH_UPPER_Z) || (b >= CH_LOWER_A && b <= CH_LOWER_Z)
             || b == CH_UNDERSCORE;
   endfunction

   function automatic bit is_digit(logic [7:0] b);
      return b >= CH_ZERO && b <= CH_NINE;
   endfunction

   function automatic void push_token(token_kind_type kind, logic [OFFSET_WIDTH-1:0] start,
                                      logic [OFFSET_WIDTH-1:0] len,
                                      logic [LINE_WIDTH-1:0] line);
      expected_token_type t;
      t.tok.kind   = kind;
      t.tok.start  = FIELD_W'(start);
      t.tok.length = FIELD_W'(len);
      t.tok.line   = FIELD_W'(line);
      t.last       = 1'b0;
      pending_tokens.push_back(t);
   endfunction

   function automatic void close_run();
      if (run_state == RUN_IDENT)
         push_token(KIND_IDENT, run_start, run_length, run_line);
      else if (run_state == RUN_NUMBER)
         push_token(KIND_NUMBER, run_start, run_length, run_line);
      run_state  = RUN_NONE;
      run_length = '0;
   endfunction

   function automatic void start_run(run_kind_type kind);
      run_state  = kind;
      run_start  = byte_offset;
      run_length = OFFSET_WIDTH'(1);
      run_line   = line_count;
   endfunction

   function automatic void predict_tokens(logic [7:0] b);
      int before_count;
      before_count = pending_tokens.size();
      if (b == CH_NUL) begin
         close_run();
         push_token(KIND_END, byte_offset, '0, line_count);
         run_start   = '0;
         run_line    = LINE_WIDTH'(1);
         byte_offset = '0;
         line_count  = LINE_WIDTH'(1);
      end else begin
         if (is_blank(b)) begin
            close_run();
            if (b == CH_NEWLINE)
               line_count = line_inc(line_count);
         end else if (is_word_start(b)) begin
            if (run_state == RUN_IDENT)
               run_length = offset_inc(run_length);
            else begin
               close_run();
               start_run(RUN_IDENT);
            end
         end else if (is_digit(b)) begin
            // digits extend identifiers as well as numbers
            if (run_state == RUN_IDENT || run_state == RUN_NUMBER)
               run_length = offset_inc(run_length);
            else begin
               close_run();
               start_run(RUN_NUMBER);
            end
         end else begin
            close_run();
            push_token(KIND_SYMBOL, byte_offset, OFFSET_WIDTH'(1), line_count);
         end
         byte_offset = offset_inc(byte_offset);
      end
      if (pending_tokens.size() > before_count)
         pending_tokens[$].last = 1'b1;
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         mismatches++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      expected_token_type want;
      if (reset) begin
         run_state   = RUN_NONE;
         run_start   = '0;
         run_length  = '0;
         run_line    = LINE_WIDTH'(1);
         byte_offset = '0;
         line_count  = LINE_WIDTH'(1);
         pending_tokens.delete();
      end else begin
         // tokens are registered, so a result never stems from a byte taken at this edge
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_tokens.size() == 0) begin
               mismatches++;
               $error("unexpected token: kind %0d start %0d length %0d line %0d",
                      rsp_ch.token_kind, rsp_ch.token_start, rsp_ch.token_length,
                      rsp_ch.token_line);
            end else begin
               want = pending_tokens.pop_front();
               check_field("token_kind", 16'(want.tok.kind), 16'(rsp_ch.token_kind));
               check_field("token_start", want.tok.start, rsp_ch.token_start);
               check_field("token_length", want.tok.length, rsp_ch.token_length);
               check_field("token_line", want.tok.line, rsp_ch.token_line);
               check_field("last_of_run", 16'(want.last), 16'(rsp_ch.last_of_run));
            end
         end
         if (req_ch.valid && req_ch.ready)
            predict_tokens(req_ch.text_byte);
      end
      outstanding <= pending_tokens.size();
   end

endmodule

>>> tb/tb_top.sv
// Top of the tokenizer testbench: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module tb_top
   import bst_pkg::*;
;

   // Cycles with no handshake on either channel before the run is abandoned.
   // The slowest legal stretch is a long receiver stall at 86 % idling; this
   // limit leaves a wide margin.
   localparam int WATCHDOG_LIMIT = 20000;
   // Least number of random bytes per phase, three phases in all
   localparam int PHASE_BYTES    = 640;

   logic clock;
   logic reset;

   bst_req_if req_ch ();
   bst_rsp_if rsp_ch ();

   int fail_count;
   int outstanding;
   int sender_idle_pct   = 0;
   int receiver_idle_pct = 0;
   int quiet_cycles      = 0;

   logic [7:0] text_q[$];

   byte_stream_tokenizer_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   tb_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: ready is re-rolled every cycle at the current idling rate
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   // Watchdog: any accepted item on either side restarts the count
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // One byte onto the request channel. An idle gap, if rolled, lowers valid
   // first; otherwise valid simply stays high and only the byte changes, so
   // valid never sees two assignments in one step.
   task automatic send_text_byte(input logic [7:0] b);
      if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < sender_idle_pct);
      end
      req_ch.valid     <= 1'b1;
      req_ch.text_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_queued_text();
      while (text_q.size() != 0)
         send_text_byte(text_q.pop_front());
   endtask

   // Hold the sender off until every predicted token has been taken
   task automatic drain_tokens();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   function automatic logic [7:0] random_word_char(bit with_digits);
      case ($urandom_range(0, with_digits ? 3 : 2))
         0:       return CH_UPPER_A + 8'($urandom_range(0, 25));
         1:       return CH_LOWER_A + 8'($urandom_range(0, 25));
         2:       return CH_UNDERSCORE;
         default: return CH_ZERO + 8'($urandom_range(0, 9));
      endcase
   endfunction

   function automatic logic [7:0] random_blank();
      logic [7:0] pick;
      pick = 8'($urandom_range(0, 5));
      return (pick == 8'd5) ? CH_SPACE : CH_TAB + pick;
   endfunction

   // Any nonzero byte outside letters, digits, underscore and whitespace
   function automatic logic [7:0] random_symbol();
      logic [7:0] pick;
      case ($urandom_range(0, 5))
         0: pick = 8'($urandom_range(1, 8));
         1: pick = 8'($urandom_range(14, 31));
         2: pick = 8'($urandom_range(33, 47));
         3: pick = 8'($urandom_range(58, 64));
         4: begin
            pick = 8'($urandom_range(91, 95));
            if (pick == CH_UNDERSCORE)
               pick = 8'd96;
         end
         default: pick = 8'($urandom_range(123, 255));
      endcase
      return pick;
   endfunction

   // Mostly well-formed text: words, numbers, symbols and whitespace, usually
   // closed by a zero byte; a share of raw noise and unterminated texts
   task automatic compose_random_text();
      repeat ($urandom_range(1, 12)) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               text_q.push_back(random_word_char(1'b0));
               repeat ($urandom_range(0, 7))
                  text_q.push_back(random_word_char(1'b1));
            end
            4, 5: begin
               repeat ($urandom_range(1, 5))
                  text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            end
            6: text_q.push_back(random_symbol());
            7: text_q.push_back(CH_NEWLINE);
            8: text_q.push_back(8'($urandom_range(0, 255)));
            default: begin
               repeat ($urandom_range(1, 4))
                  text_q.push_back(8'($urandom_range(128, 255)));
            end
         endcase
         // adjacent tokens with no separator a third of the time
         if ($urandom_range(0, 2) != 0)
            text_q.push_back(random_blank());
      end
      if ($urandom_range(0, 9) != 0)
         text_q.push_back(CH_NUL);
   endtask

   initial begin
      int sent;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.text_byte <= 8'd0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct   = 38;
               receiver_idle_pct = 86;
            end
            1: begin
               sender_idle_pct   = 86;
               receiver_idle_pct = 38;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
         endcase

         if (phase == 0) begin
            // Directed text: identifier with digits and underscore closed by a
            // tab, number then letter, newline closing a run, bare whitespace,
            // top and high-bit symbols, number then symbol, run then end,
            // end with no run, number then end on line two
            text_q = '{CH_UPPER_Z, CH_LOWER_A, CH_UNDERSCORE, CH_NINE, CH_ZERO, CH_TAB,
                       CH_ZERO, CH_NINE, CH_LOWER_Z, CH_UPPER_A, CH_NEWLINE,
                       CH_CR, 8'd11, 8'd12, CH_SPACE, 8'd255,
                       CH_NINE, 8'd128, 8'd127, CH_LOWER_A, CH_NUL, CH_NUL,
                       CH_NEWLINE, CH_NINE, CH_NUL};
            send_queued_text();
            drain_tokens();
         end

         sent = 0;
         while (sent < PHASE_BYTES) begin
            compose_random_text();
            sent += text_q.size();
            send_queued_text();
         end
         // close any text left open so the next phase starts cleanly
         text_q.push_back(CH_NUL);
         send_queued_text();

         drain_tokens();
      end

      // Nothing left to predict; wait before the verdict so the pipeline can
      // show any stray token
      repeat (10) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
